### hdl/dlcc_pkg.sv
package dlcc_pkg;

  localparam int LIST_DEPTH_DEF = 512;

  localparam int WORD_W  = 16;
  localparam int PC_W    = 9;
  localparam int COORD_W = 10;

  // Port addresses (low 12 bits).
  localparam logic [11:0] PORT_ENABLE = 12'hd20;
  localparam logic [11:0] PORT_COLOR  = 12'hd22;
  localparam logic [11:0] PORT_PAN    = 12'hd23;
  localparam logic [11:0] PORT_ALPHA  = 12'hd24;
  // Program window 0x400..0x5ff: the top three address bits select it.
  localparam logic [2:0]  PORT_PROG_HI = 3'b010;

  // Instruction opcodes, bits 15..12.
  localparam logic [3:0] OP_JUMP      = 4'h1;
  localparam logic [3:0] OP_WAIT_V    = 4'h2;
  localparam logic [3:0] OP_WAIT_H    = 4'h3;
  localparam logic [3:0] OP_SKIP_V    = 4'h4;
  localparam logic [3:0] OP_SKIP_H    = 4'h5;
  localparam logic [3:0] OP_COLOR_NL  = 4'h6;
  localparam logic [3:0] OP_WAIT_VREL = 4'h7;
  localparam logic [3:0] OP_WAIT_HREL = 4'h8;
  localparam logic [3:0] OP_PAN       = 4'ha;
  localparam logic [3:0] OP_PAN_NL    = 4'hb;
  localparam logic [3:0] OP_COLOR     = 4'hc;
  localparam logic [3:0] OP_ALPHA     = 4'hd;

  typedef struct packed {
    logic              en;
    logic [PC_W-1:0]   addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [31:0]        bg_color;
    logic [COORD_W-1:0] pan_x;
    logic               alpha_override;
  } result_t;

endpackage

### hdl/dlcc_ram.sv
module dlcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dlcc_fetch.sv
module dlcc_fetch #(
  parameter int LIST_DEPTH = dlcc_pkg::LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dlcc_pkg::PC_W-1:0]     pc_next,
  input  dlcc_pkg::ram_wr_t             wr,
  output logic [dlcc_pkg::WORD_W-1:0]   instr
);
  import dlcc_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              wr_in_range;
  logic              rd_in_range;
  logic              we;
  logic [WORD_W-1:0] rdata;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;
  logic              in_range_q;

  assign raddr       = pc_next[AW-1:0];
  assign waddr       = wr.addr[AW-1:0];
  assign wr_in_range = {1'b0, wr.addr} < (PC_W + 1)'(LIST_DEPTH);
  assign rd_in_range = {1'b0, pc_next} < (PC_W + 1)'(LIST_DEPTH);
  assign we          = wr.en && wr_in_range;

  dlcc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LIST_DEPTH)
  ) u_prog_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The RAM returns the old word when the entry being prefetched is written
  // in the same cycle, so the new word is carried over here.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit    <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      fwd_hit    <= we && (waddr == raddr) && rd_in_range;
      in_range_q <= rd_in_range;
    end
    fwd_data <= wr.data;
  end

  assign instr = !in_range_q ? '0 : (fwd_hit ? fwd_data : rdata);

endmodule

### hdl/dlcc_seq.sv
module dlcc_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         cmd,
  input  logic [11:0]                  port_addr,
  input  logic [15:0]                  write_value,
  input  logic [dlcc_pkg::COORD_W-1:0] pixel_x,
  input  logic [dlcc_pkg::COORD_W-1:0] pixel_y,
  input  logic [dlcc_pkg::WORD_W-1:0]  instr,
  output logic [dlcc_pkg::PC_W-1:0]    pc_next,
  output dlcc_pkg::ram_wr_t            wr,
  output logic                         push,
  output dlcc_pkg::result_t            result
);
  import dlcc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BEGIN = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_WAITH = 5'b01000,
    ST_WAITV = 5'b10000
  } run_state_t;

  run_state_t         state, state_next;
  logic [PC_W-1:0]    pc;
  logic [COORD_W:0]   target, target_next;
  logic               run_enable, run_enable_next;
  logic [7:0]         red, red_next;
  logic [7:0]         green, green_next;
  logic [7:0]         blue, blue_next;
  logic [7:0]         alpha, alpha_next;
  logic               override, override_next;
  logic [COORD_W-1:0] pan, pan_next;

  logic [3:0]         opcode;
  logic [COORD_W-1:0] arg;
  logic [PC_W-1:0]    pc_inc;
  logic [PC_W-1:0]    pc_skip;
  logic [COORD_W:0]   next_line;
  logic [COORD_W:0]   y_rel;
  logic [COORD_W:0]   x_rel;

  assign opcode    = instr[15:12];
  assign arg       = instr[COORD_W-1:0];
  assign pc_inc    = pc + PC_W'(1);
  assign pc_skip   = pc + PC_W'(2);
  assign next_line = {1'b0, pixel_y} + (COORD_W + 1)'(1);
  assign y_rel     = {1'b0, pixel_y} + {1'b0, arg};
  assign x_rel     = {1'b0, pixel_x} + {1'b0, arg};

  always_comb begin
    state_next      = state;
    pc_next         = pc;
    target_next     = target;
    run_enable_next = run_enable;
    red_next        = red;
    green_next      = green;
    blue_next       = blue;
    alpha_next      = alpha;
    override_next   = override;
    pan_next        = pan;
    wr              = '0;
    if (accept) begin
      if (cmd) begin
        case (port_addr)
          PORT_ENABLE: run_enable_next = write_value[0];
          PORT_COLOR: begin
            red_next   = {write_value[11:8], 4'h0};
            green_next = {write_value[7:4], 4'h0};
            blue_next  = {write_value[3:0], 4'h0};
          end
          PORT_PAN: pan_next = {1'b0, write_value[8:0]};
          PORT_ALPHA: begin
            override_next = write_value[15];
            alpha_next    = {write_value[3:0], 4'h0};
          end
          default: begin
            if (port_addr[11:9] == PORT_PROG_HI) begin
              wr.en   = 1'b1;
              wr.addr = port_addr[PC_W-1:0];
              wr.data = write_value;
            end
          end
        endcase
      end else if (pixel_y == '0) begin
        // The top row restarts the list, or parks the sequencer when disabled.
        if (run_enable) begin
          state_next = ST_BEGIN;
          pc_next    = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end else begin
        case (state)
          ST_BEGIN: state_next = ST_EXEC;
          ST_EXEC: begin
            pc_next = pc_inc;
            case (opcode)
              OP_JUMP: pc_next = instr[PC_W-1:0];
              OP_WAIT_V: begin
                target_next = {1'b0, arg};
                state_next  = ST_WAITV;
              end
              OP_WAIT_H: begin
                target_next = {1'b0, arg};
                state_next  = ST_WAITH;
              end
              OP_SKIP_V: begin
                if (pixel_y >= arg) begin
                  pc_next    = pc_skip;
                  state_next = ST_BEGIN;
                end
              end
              OP_SKIP_H: begin
                if (pixel_x >= arg) begin
                  pc_next    = pc_skip;
                  state_next = ST_BEGIN;
                end
              end
              OP_COLOR_NL: begin
                red_next    = {instr[11:8], 4'h0};
                green_next  = {instr[7:4], 4'h0};
                blue_next   = {instr[3:0], 4'h0};
                target_next = next_line;
                state_next  = ST_WAITV;
              end
              OP_WAIT_VREL: begin
                target_next = y_rel;
                state_next  = ST_WAITV;
              end
              OP_WAIT_HREL: begin
                target_next = x_rel;
                state_next  = ST_WAITH;
              end
              OP_PAN: pan_next = arg;
              OP_PAN_NL: begin
                pan_next    = arg;
                target_next = next_line;
                state_next  = ST_WAITV;
              end
              OP_COLOR: begin
                red_next   = {instr[11:8], 4'h0};
                green_next = {instr[7:4], 4'h0};
                blue_next  = {instr[3:0], 4'h0};
              end
              OP_ALPHA: alpha_next = {instr[3:0], 4'h0};
              default: ;
            endcase
          end
          ST_WAITH: begin
            if ({1'b0, pixel_x} >= target) begin
              state_next = ST_EXEC;
            end
          end
          ST_WAITV: begin
            if ({1'b0, pixel_y} >= target) begin
              state_next = ST_EXEC;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      target     <= '0;
      run_enable <= 1'b0;
      red        <= 8'hff;
      green      <= 8'h00;
      blue       <= 8'h00;
      alpha      <= 8'hff;
      override   <= 1'b1;
      pan        <= '0;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      target     <= target_next;
      run_enable <= run_enable_next;
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
      alpha      <= alpha_next;
      override   <= override_next;
      pan        <= pan_next;
    end
  end

  assign push                  = accept && !cmd;
  assign result.bg_color       = {alpha_next, blue_next, green_next, red_next};
  assign result.pan_x          = pan_next;
  assign result.alpha_override = override_next;

  a_row_zero_restart: assert property (@(posedge clk) disable iff (rst)
    accept && !cmd && (pixel_y == '0) && run_enable |=> (state == ST_BEGIN) && (pc == '0))
    else $error("top row did not restart the list");

  a_port_write_keeps_sequencer: assert property (@(posedge clk) disable iff (rst)
    accept && cmd |=> $stable(pc) && $stable(state) && $stable(target))
    else $error("port write disturbed the sequencer");

  a_idle_cycle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pc) && $stable(state) && $stable(pan) && $stable(alpha))
    else $error("state changed without an accepted item");

endmodule

### hdl/dlcc_outq.sv
module dlcc_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dlcc_pkg::result_t result,
  input  logic              out_stall,
  output logic              out_valid,
  output dlcc_pkg::result_t out_item,
  output logic              full
);
  import dlcc_pkg::*;

  result_t skid_item;
  logic    skid_valid;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_item <= result;
      end else begin
        out_item <= result;
      end
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_blocked_push_parks: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && out_stall && !skid_valid |=> skid_valid && out_valid)
    else $error("item pushed behind a stalled output was lost");

endmodule

### hdl/display_list_copper_coprocessor_top.sv
// Display-list coprocessor: port writes (cmd = 1) load the 512-entry program
// window at 0x400..0x5ff and set enable, color, pan and alpha; they return no
// item. Each pixel tick (cmd = 0) steps the sequencer once and returns one item
// with the background word, the pan and the alpha override flag. The block
// takes one item per clock with no bubbles while in_stall is low: the program
// RAM is read ahead at the program counter settled by the previous item, and
// a write to that entry is forwarded into the fetched word. Results leave
// through an output register backed by a one-entry skid stage, so in_stall
// rises only when both hold an untaken item. No clearing pass follows reset;
// program entries must be written before the sequencer reaches them.
module display_list_copper_coprocessor_top #(
  parameter int LIST_DEPTH = dlcc_pkg::LIST_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [11:0]                  port_addr,
  input  logic [15:0]                  write_value,
  input  logic [dlcc_pkg::COORD_W-1:0] pixel_x,
  input  logic [dlcc_pkg::COORD_W-1:0] pixel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  bg_color,
  output logic [dlcc_pkg::COORD_W-1:0] pan_x,
  output logic                         alpha_override
);
  import dlcc_pkg::*;

  logic              accept;
  logic [PC_W-1:0]   pc_next;
  ram_wr_t           wr;
  logic [WORD_W-1:0] instr;
  logic              push;
  result_t           result;
  result_t           out_item;
  logic              full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full;

  dlcc_fetch #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_fetch (
    .clk     (clk),
    .rst     (rst),
    .pc_next (pc_next),
    .wr      (wr),
    .instr   (instr)
  );

  dlcc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .port_addr   (port_addr),
    .write_value (write_value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .instr       (instr),
    .pc_next     (pc_next),
    .wr          (wr),
    .push        (push),
    .result      (result)
  );

  dlcc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .full      (full)
  );

  assign bg_color       = out_item.bg_color;
  assign pan_x          = out_item.pan_x;
  assign alpha_override = out_item.alpha_override;

endmodule

### tb/tb_display_list_copper_coprocessor_top.sv
`timescale 1ns / 100ps

module tb_display_list_copper_coprocessor_top;
  import dlcc_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int IDLE_PCT    = 36;

  // Opcodes the block treats as no-ops, plus the ignored y-flip port.
  localparam logic [3:0]  OP_NOP     = 4'h0;
  localparam logic [3:0]  OP_SPARE_9 = 4'h9;
  localparam logic [3:0]  OP_SPARE_F = 4'hf;
  localparam logic [11:0] PORT_YFLIP = 12'hd21;
  localparam logic [11:0] PROG_BASE  = {PORT_PROG_HI, 9'd0};

  typedef enum logic [4:0] {
    SEQ_IDLE   = 5'b00001,
    SEQ_BEGIN  = 5'b00010,
    SEQ_EXEC   = 5'b00100,
    SEQ_WAIT_H = 5'b01000,
    SEQ_WAIT_V = 5'b10000
  } seq_state_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = 1'b0;
  logic [11:0]         port_addr = '0;
  logic [15:0]         write_value = '0;
  logic [COORD_W-1:0]  pixel_x = '0;
  logic [COORD_W-1:0]  pixel_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         bg_color;
  logic [COORD_W-1:0]  pan_x;
  logic                alpha_override;

  // Predicted sequencer and display state.
  logic [15:0]  prog_word [LIST_DEPTH_DEF];
  bit           prog_known [LIST_DEPTH_DEF];
  seq_state_t   seq_state = SEQ_IDLE;
  logic [8:0]   prog_pc = '0;
  logic [15:0]  wait_tgt = '0;
  logic         run_en = 1'b0;
  logic [7:0]   red_lvl = 8'hff;
  logic [7:0]   green_lvl = 8'h00;
  logic [7:0]   blue_lvl = 8'h00;
  logic [7:0]   alpha_lvl = 8'hff;
  logic         ovr_flag = 1'b1;
  logic [9:0]   pan_lvl = '0;

  result_t expected_pixels [$];
  result_t head_px;

  int idle_pct = IDLE_PCT;
  int stall_pct = IDLE_PCT;
  int hold_left = 0;
  int prog_span = 16;
  int mismatches = 0;
  int pixels_checked = 0;
  int ticks_sent = 0;
  int writes_sent = 0;

  display_list_copper_coprocessor_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .port_addr      (port_addr),
    .write_value    (write_value),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bg_color       (bg_color),
    .pan_x          (pan_x),
    .alpha_override (alpha_override)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("display_list_copper_coprocessor_top: mismatch");
    $finish;
  end

  function automatic void paint_color(input logic [11:0] rgb);
    red_lvl   = {rgb[11:8], 4'h0};
    green_lvl = {rgb[7:4], 4'h0};
    blue_lvl  = {rgb[3:0], 4'h0};
  endfunction

  function automatic void apply_port_write(input logic [11:0] addr, input logic [15:0] val);
    case (addr)
      PORT_ENABLE: run_en = val[0];
      PORT_COLOR:  paint_color(val[11:0]);
      PORT_PAN:    pan_lvl = {1'b0, val[8:0]};
      PORT_ALPHA: begin
        ovr_flag  = val[15];
        alpha_lvl = {val[3:0], 4'h0};
      end
      default: begin
        if (addr[11:9] == PORT_PROG_HI) begin
          prog_word[addr[8:0]]  = val;
          prog_known[addr[8:0]] = 1'b1;
        end else begin
          return;
        end
      end
    endcase
    writes_sent++;
  endfunction

  function automatic void execute_word(input logic [9:0] bx, input logic [9:0] by);
    logic [15:0] word;
    logic [9:0]  arg;
    logic [8:0]  next_pc;
    word    = prog_word[prog_pc];
    arg     = word[9:0];
    next_pc = prog_pc + 9'd1;
    case (word[15:12])
      OP_JUMP: next_pc = word[8:0];
      OP_WAIT_V: begin
        wait_tgt  = {6'd0, arg};
        seq_state = SEQ_WAIT_V;
      end
      OP_WAIT_H: begin
        wait_tgt  = {6'd0, arg};
        seq_state = SEQ_WAIT_H;
      end
      OP_SKIP_V: begin
        if (by >= arg) begin
          seq_state = SEQ_BEGIN;
          next_pc   = prog_pc + 9'd2;
        end
      end
      OP_SKIP_H: begin
        if (bx >= arg) begin
          seq_state = SEQ_BEGIN;
          next_pc   = prog_pc + 9'd2;
        end
      end
      OP_COLOR_NL: begin
        paint_color(word[11:0]);
        wait_tgt  = {6'd0, by} + 16'd1;
        seq_state = SEQ_WAIT_V;
      end
      OP_WAIT_VREL: begin
        wait_tgt  = {6'd0, by} + {6'd0, arg};
        seq_state = SEQ_WAIT_V;
      end
      OP_WAIT_HREL: begin
        wait_tgt  = {6'd0, bx} + {6'd0, arg};
        seq_state = SEQ_WAIT_H;
      end
      OP_PAN: pan_lvl = arg;
      OP_PAN_NL: begin
        pan_lvl   = arg;
        wait_tgt  = {6'd0, by} + 16'd1;
        seq_state = SEQ_WAIT_V;
      end
      OP_COLOR: paint_color(word[11:0]);
      OP_ALPHA: alpha_lvl = {word[3:0], 4'h0};
      default: ;
    endcase
    prog_pc = next_pc;
  endfunction

  function automatic result_t step_sequencer(input logic [9:0] bx, input logic [9:0] by);
    result_t px;
    if (by == 10'd0) begin
      if (run_en) begin
        seq_state = SEQ_BEGIN;
        prog_pc   = '0;
      end else begin
        seq_state = SEQ_IDLE;
      end
    end else begin
      case (seq_state)
        SEQ_BEGIN:  seq_state = SEQ_EXEC;
        SEQ_EXEC:   execute_word(bx, by);
        SEQ_WAIT_H: if ({6'd0, bx} >= wait_tgt) seq_state = SEQ_EXEC;
        SEQ_WAIT_V: if ({6'd0, by} >= wait_tgt) seq_state = SEQ_EXEC;
        default: ;
      endcase
    end
    ticks_sent++;
    px.bg_color       = {alpha_lvl, blue_lvl, green_lvl, red_lvl};
    px.pan_x          = pan_lvl;
    px.alpha_override = ovr_flag;
    return px;
  endfunction

  function automatic logic [15:0] random_insn();
    logic [3:0] op;
    logic [1:0] pad;
    logic [9:0] arg;
    logic [8:0] dest;
    op  = 4'($urandom_range(15));
    pad = 2'($urandom);
    arg = 10'($urandom);
    if (op == OP_JUMP) begin
      // Jumps mostly stay inside the current list; a few land anywhere.
      if ($urandom_range(7) == 0) dest = 9'($urandom);
      else dest = 9'($urandom_range(prog_span - 1));
      arg[8:0] = dest;
    end else if ($urandom_range(3) != 0) begin
      arg = 10'($urandom_range(12));
    end
    return {op, pad, arg};
  endfunction

  // Results are sampled with the values in force before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel tick pending: bg_color %h", bg_color);
        mismatches++;
      end else begin
        head_px = expected_pixels.pop_front();
        pixels_checked++;
        if (bg_color !== head_px.bg_color) begin
          $error("bg_color expected %h actual %h", head_px.bg_color, bg_color);
          mismatches++;
        end
        if (pan_x !== head_px.pan_x) begin
          $error("pan_x expected %h actual %h", head_px.pan_x, pan_x);
          mismatches++;
        end
        if (alpha_override !== head_px.alpha_override) begin
          $error("alpha_override expected %b actual %b", head_px.alpha_override,
                 alpha_override);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input bit is_write, input logic [11:0] addr, input logic [15:0] val,
                           input logic [9:0] bx, input logic [9:0] by);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    cmd         <= is_write;
    port_addr   <= addr;
    write_value <= val;
    pixel_x     <= bx;
    pixel_y     <= by;
    do @(posedge clk); while (in_stall);
    if (is_write) apply_port_write(addr, val);
    else expected_pixels.push_back(step_sequencer(bx, by));
  endtask

  task automatic write_entry(input logic [8:0] idx, input logic [15:0] word);
    send_item(1'b1, PROG_BASE | {3'd0, idx}, word, 10'($urandom), 10'($urandom));
  endtask

  // An entry that the sequencer is about to execute and that was never written gets written first.
  task automatic beam_tick(input logic [9:0] bx, input logic [9:0] by);
    if (by != 10'd0 && seq_state == SEQ_EXEC && !prog_known[prog_pc])
      write_entry(prog_pc, random_insn());
    send_item(1'b0, 12'($urandom), 16'($urandom), bx, by);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic load_program(input int len);
    logic [15:0] en_word;
    prog_span = len;
    for (int i = 0; i < len; i++) write_entry(9'(i), random_insn());
    en_word    = 16'($urandom);
    en_word[0] = 1'b1;
    send_item(1'b1, PORT_ENABLE, en_word, 10'($urandom), 10'($urandom));
  endtask

  task automatic inject_noise();
    logic [11:0] reg_port;
    case ($urandom_range(5))
      0: send_item(1'b1, 12'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
      1: send_item(1'b1, PORT_YFLIP, 16'($urandom), 10'($urandom), 10'($urandom));
      2: begin
        case ($urandom_range(3))
          0:       reg_port = PORT_COLOR;
          1:       reg_port = PORT_PAN;
          2:       reg_port = PORT_ALPHA;
          default: reg_port = PORT_ENABLE;
        endcase
        send_item(1'b1, reg_port, 16'($urandom), 10'($urandom), 10'($urandom));
      end
      3: write_entry(9'($urandom_range(prog_span - 1)), random_insn());
      default: beam_tick(10'($urandom), 10'($urandom));
    endcase
  endtask

  task automatic raster_frame(input int cols, input int rows, input int xstep, input int ystep);
    int bx;
    int by;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if ($urandom_range(24) == 0) inject_noise();
        bx = c * xstep;
        by = r * ystep;
        if (bx > 1023) bx = 1023;
        if (by > 1023) by = 1023;
        beam_tick(10'(bx), 10'(by));
      end
    end
  endtask

  task automatic test_reset_state();
    beam_tick(10'd0, 10'd0);
    beam_tick(10'h3ff, 10'h3ff);
  endtask

  task automatic test_port_writes();
    send_item(1'b1, PORT_COLOR, 16'hfabc, 10'h3ff, 10'h3ff);
    send_item(1'b1, PORT_PAN, 16'hffff, 10'd0, 10'd0);
    send_item(1'b1, PORT_ALPHA, 16'h800f, 10'd0, 10'd0);
    send_item(1'b1, PORT_YFLIP, 16'hffff, 10'd0, 10'd0);
    send_item(1'b1, 12'(PROG_BASE + LIST_DEPTH_DEF), 16'hffff, 10'd0, 10'd0);
    send_item(1'b1, PROG_BASE - 12'd1, 16'hffff, 10'd0, 10'd0);
    beam_tick(10'd512, 10'd0);
    send_item(1'b1, PORT_ALPHA, 16'h7ff0, 10'd0, 10'd0);
    beam_tick(10'd0, 10'd0);
  endtask

  task automatic test_every_opcode();
    write_entry(9'd0, {OP_PAN, 12'h3ff});
    write_entry(9'd1, {OP_COLOR, 12'h5a3});
    write_entry(9'd2, {OP_ALPHA, 12'hffc});
    write_entry(9'd3, {OP_SKIP_H, 12'h000});
    write_entry(9'd4, {OP_NOP, 12'hfff});
    write_entry(9'd5, {OP_SKIP_V, 12'h3ff});
    write_entry(9'd6, {OP_WAIT_HREL, 12'h000});
    write_entry(9'd7, {OP_WAIT_H, 12'h000});
    write_entry(9'd8, {OP_WAIT_VREL, 12'h000});
    write_entry(9'd9, {OP_WAIT_V, 12'h000});
    write_entry(9'd10, {OP_COLOR_NL, 12'hfff});
    write_entry(9'd11, {OP_PAN_NL, 12'h200});
    write_entry(9'd12, {OP_SPARE_9, 12'hfff});
    // Jump to the last entry; the no-op there wraps the counter to zero.
    write_entry(9'd13, {OP_JUMP, 12'hdff});
    write_entry(9'd511, {OP_SPARE_F, 12'h000});
    prog_span = 14;
    send_item(1'b1, PORT_ENABLE, 16'h0001, 10'd0, 10'd0);
    beam_tick(10'd0, 10'd0);
    for (int x = 0; x < 18; x++) beam_tick(10'(x), 10'd1);
    for (int x = 0; x < 3; x++) beam_tick(10'(x), 10'd2);
    for (int x = 0; x < 5; x++) beam_tick(10'(x), 10'd3);
    beam_tick(10'h3ff, 10'h3ff);
    send_item(1'b1, PORT_ENABLE, 16'hfffe, 10'd0, 10'd0);
    beam_tick(10'd0, 10'd0);
  endtask

  task automatic test_full_rate();
    idle_pct  = 0;
    stall_pct = 0;
    load_program(12);
    raster_frame(16, 4, 1, 1);
    raster_frame(12, 3, 90, 300);
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  task automatic test_output_backpressure();
    idle_pct  = 0;
    hold_left = 50;
    raster_frame(10, 3, 7, 3);
    idle_pct  = IDLE_PCT;
  endtask

  task automatic test_drain_pause();
    raster_frame(6, 2, 1, 1);
    drain_results();
    raster_frame(6, 2, 50, 200);
  endtask

  task automatic test_random_frames();
    int xstep;
    int ystep;
    while (ticks_sent + writes_sent < ITEM_TARGET) begin
      if (!run_en || $urandom_range(2) == 0) load_program($urandom_range(3, 24));
      if ($urandom_range(11) == 0) hold_left = $urandom_range(20, 60);
      xstep = $urandom_range(1) ? 1 : $urandom_range(1, 110);
      ystep = $urandom_range(1) ? 1 : $urandom_range(1, 150);
      raster_frame($urandom_range(3, 14), $urandom_range(2, 8), xstep, ystep);
      if ($urandom_range(5) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_port_writes();
    test_every_opcode();
    test_full_rate();
    test_output_backpressure();
    test_drain_pause();
    test_random_frames();
    drain_results();
    repeat (16) @(posedge clk);
    $display("Covered %0d pixel ticks and %0d decoded port writes; %0d results compared.",
             ticks_sent, writes_sent, pixels_checked);
    if (mismatches == 0) begin
      $display("display_list_copper_coprocessor_top: match");
    end else begin
      $display("display_list_copper_coprocessor_top: mismatch");
    end
    $finish;
  end

endmodule
